@@ rtl/raw_bayer_byte_unpacker_assert.svh @@
// assertion helpers for the raw bayer byte unpacker
`ifndef RAW_BAYER_BYTE_UNPACKER_ASSERT_SVH
`define RAW_BAYER_BYTE_UNPACKER_ASSERT_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define RBU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rbu: implication check failed");

// next-cycle implication
`define RBU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbu: next-cycle check failed");

`endif

@@ rtl/rbu_pkg.sv @@
package rbu_pkg;

    localparam int MAX_ROW_PIXELS = 8192;
    localparam int COL_W          = 14;
    localparam int PIX_W          = 16;
    localparam int GRP_PIX        = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    // pixel format codes
    localparam logic [1:0] FMT_RAW10 = 2'd0;
    localparam logic [1:0] FMT_RAW12 = 2'd1;
    localparam logic [1:0] FMT_RAW16 = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [2:0] REG_LITTLE_ENDIAN = 3'd1;
    localparam logic [2:0] REG_MSB_ALIGNED   = 3'd2;
    localparam logic [2:0] REG_VALID_BITS    = 3'd3;
    localparam logic [2:0] REG_ROW_PIXELS    = 3'd4;

    typedef struct packed {
        logic [1:0]       pixel_format;
        logic             little_endian;
        logic             msb_aligned;
        logic [4:0]       valid_bits;
        logic [COL_W-1:0] row_pixels;
    } rbu_cfg_t;

    // one completed group with the pixels that survive the row limit
    typedef struct packed {
        logic [GRP_PIX-1:0][PIX_W-1:0] px;
        logic [GRP_PIX-1:0]            row_end;
        logic [1:0]                    last_idx;
    } rbu_grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rbu_fifo_st_t;

endpackage

@@ rtl/rbu_front.sv @@
module rbu_front
    import rbu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  rbu_cfg_t     cfg,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    input  rbu_fifo_st_t fifo_st,
    output logic         push,
    output rbu_grp_t     push_data
);

    localparam logic [COL_W-1:0] ROW_LIMIT = COL_W'(MAX_ROW_PIXELS);

    logic [7:0]       group_bytes_reg [GRP_PIX];
    logic [2:0]       phase_reg, phase_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic             accept;
    logic [2:0]       phase_eff;
    logic [COL_W-1:0] col_eff;
    logic [COL_W-1:0] limit;
    logic [COL_W-1:0] avail;
    logic [2:0]       glen_m1;
    logic [2:0]       count;
    logic [2:0]       keep_n;
    logic             complete;
    logic             fmt_valid;
    logic [PIX_W-1:0] raw16_v;
    logic [PIX_W-1:0] raw16_px;
    logic [PIX_W-1:0] mask16;

    assign s_tready = !fifo_st.full;
    assign accept   = s_tvalid && s_tready;

    assign phase_eff = s_tuser ? 3'd0 : phase_reg;
    assign col_eff   = s_tuser ? '0 : col_reg;
    assign limit     = (cfg.row_pixels >= ROW_LIMIT) ? ROW_LIMIT : cfg.row_pixels;
    assign avail     = (col_eff < limit) ? (limit - col_eff) : '0;

    always_comb begin
        fmt_valid = 1'b1;
        unique case (cfg.pixel_format)
            FMT_RAW10: begin glen_m1 = 3'd4; count = 3'd4; end
            FMT_RAW12: begin glen_m1 = 3'd2; count = 3'd2; end
            FMT_RAW16: begin glen_m1 = 3'd1; count = 3'd1; end
            default: begin glen_m1 = 3'd0; count = 3'd0; fmt_valid = 1'b0; end
        endcase
    end

    assign complete = fmt_valid && (phase_eff >= glen_m1);
    assign keep_n   = (avail < COL_W'(count)) ? avail[2:0] : count;

    // raw16 sample: byte order, then shift or mask down to the valid bits
    assign raw16_v = cfg.little_endian ? {s_tdata, group_bytes_reg[0]}
                                       : {group_bytes_reg[0], s_tdata};
    assign mask16  = PIX_W'((17'd1 << cfg.valid_bits) - 17'd1);

    always_comb begin
        if (cfg.valid_bits == 5'd0) begin
            raw16_px = '0;
        end else if (cfg.valid_bits < 5'd16) begin
            raw16_px = cfg.msb_aligned ? (raw16_v >> (5'd16 - cfg.valid_bits))
                                       : (raw16_v & mask16);
        end else begin
            raw16_px = raw16_v;
        end
    end

    always_comb begin
        push_data = '0;
        for (int i = 0; i < GRP_PIX; i++) begin
            unique case (cfg.pixel_format)
                FMT_RAW10: push_data.px[i] = {6'd0, group_bytes_reg[i], s_tdata[2*i +: 2]};
                FMT_RAW12: push_data.px[i] = (i < 2)
                    ? {4'd0, group_bytes_reg[i], s_tdata[(4*i) % 8 +: 4]} : '0;
                default:   push_data.px[i] = (i == 0) ? raw16_px : '0;
            endcase
            push_data.row_end[i] = ({1'b0, col_eff} + (COL_W+1)'(i + 1)) == {1'b0, limit};
        end
        push_data.last_idx = 2'(keep_n - 3'd1);
    end

    assign push = accept && complete && (keep_n != 3'd0);

    always_comb begin
        phase_next = phase_reg;
        col_next   = col_reg;
        if (accept) begin
            col_next = col_eff;
            if (!fmt_valid) begin
                phase_next = 3'd0;
            end else if (!complete) begin
                phase_next = phase_eff + 3'd1;
            end else begin
                phase_next = 3'd0;
                // column saturates at the limit once the row is full
                col_next = (col_eff >= limit) ? limit : (col_eff + COL_W'(keep_n));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 3'd0;
            col_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && fmt_valid && !complete) begin
            group_bytes_reg[phase_eff[1:0]] <= s_tdata;
        end
    end

endmodule

@@ rtl/rbu_fifo.sv @@
module rbu_fifo
    import rbu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  rbu_grp_t     push_data,
    input  logic         pop,
    output rbu_grp_t     pop_data,
    output rbu_fifo_st_t st
);

    rbu_grp_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign st.full   = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign st.empty  = (count_reg == '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/rbu_back.sv @@
module rbu_back
    import rbu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  rbu_grp_t         grp,
    input  rbu_fifo_st_t     fifo_st,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    rbu_grp_t   cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       xfer;
    logic       done;

    assign m_tvalid = valid_reg;
    assign m_tdata  = cur_reg.px[idx_reg];
    assign m_tlast  = (idx_reg == cur_reg.last_idx);
    assign m_tuser  = cur_reg.row_end[idx_reg];

    assign xfer = valid_reg && m_tready;
    assign done = xfer && m_tlast;
    // refill straight after the last pixel so groups leave without a gap
    assign pop  = !fifo_st.empty && (!valid_reg || done);

    always_comb begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (pop) begin
            cur_next   = grp;
            idx_next   = 2'd0;
            valid_next = 1'b1;
        end else if (done) begin
            valid_next = 1'b0;
        end else if (xfer) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

@@ rtl/raw_bayer_byte_unpacker.sv @@
// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  tdata = data_byte, tuser = row_start
// m_        out  m_tvalid / m_tready  tdata = pixel_value, tlast = last_of_run,
//                                     tuser = row_end
// apb       in   psel / penable       pixel_format, little_endian, msb_aligned,
//                                     valid_bits, row_pixels at 0x00..0x10
//
// one byte taken per clock while the group queue is not full; a group enters the queue on the byte that closes it
// pixels leave at one per clock from the back while m_tready is high, so the 4-entry group queue sets
// how long the output may stall before s_tready drops
// first pixel of a group is shown once the queue holds the group and the back has loaded it into cur_reg
// synchronous active-low reset, no clearing pass
module raw_bayer_byte_unpacker
    import rbu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] row_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pixel_value
    output logic        m_tlast,
    output logic        m_tuser,   // [0] row_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "raw_bayer_byte_unpacker_assert.svh"

    rbu_cfg_t     cfg_reg;
    logic         cfg_wr;
    logic [2:0]   reg_idx;
    logic         push;
    logic         pop;
    rbu_grp_t     push_data;
    rbu_grp_t     pop_data;
    rbu_fifo_st_t fifo_st;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format  <= FMT_RAW10;
            cfg_reg.little_endian <= 1'b1;
            cfg_reg.msb_aligned   <= 1'b0;
            cfg_reg.valid_bits    <= 5'd16;
            cfg_reg.row_pixels    <= COL_W'(1920);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= pwdata[1:0];
                REG_LITTLE_ENDIAN: cfg_reg.little_endian <= pwdata[0];
                REG_MSB_ALIGNED:   cfg_reg.msb_aligned   <= pwdata[0];
                REG_VALID_BITS:    cfg_reg.valid_bits    <= pwdata[4:0];
                REG_ROW_PIXELS:    cfg_reg.row_pixels    <= pwdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PIXEL_FORMAT:  prdata = {30'd0, cfg_reg.pixel_format};
            REG_LITTLE_ENDIAN: prdata = {31'd0, cfg_reg.little_endian};
            REG_MSB_ALIGNED:   prdata = {31'd0, cfg_reg.msb_aligned};
            REG_VALID_BITS:    prdata = {27'd0, cfg_reg.valid_bits};
            REG_ROW_PIXELS:    prdata = {(32-COL_W)'(0), cfg_reg.row_pixels};
            default:           prdata = '0;
        endcase
    end

    rbu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_st   (fifo_st),
        .push      (push),
        .push_data (push_data)
    );

    rbu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .st        (fifo_st)
    );

    rbu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp      (pop_data),
        .fifo_st  (fifo_st),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `RBU_ASSERT_IMPL(a_no_push_full, push, !fifo_st.full)
    `RBU_ASSERT_IMPL(a_no_pop_empty, pop, !fifo_st.empty)
    `RBU_ASSERT_NEXT(a_full_holds, fifo_st.full && !pop, fifo_st.full)

endmodule

@@ test/tb_raw_bayer_byte_unpacker.sv @@
`timescale 1ns / 100ps

module tb_raw_bayer_byte_unpacker;
    import rbu_pkg::*;

    localparam logic [1:0] FMT_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         N_PHASES       = 9;
    localparam int         PHASE_BYTES    = 34;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         LONG_STALL     = 80;

    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
        logic        row_end;
    } pixel_exp_t;

    // one row of the directed table: either a register write or a byte
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [13:0] value;
        logic [7:0]  data_byte;
        logic        row_start;
        logic        typed;
        logic [2:0]  n_px;
        logic [15:0] pixel;
    } step_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    raw_bayer_byte_unpacker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // own copy of the block's registers and unpacking state
    rbu_cfg_t    cfg;
    logic [7:0]  grp_bytes [4];
    logic [2:0]  grp_phase;
    logic [13:0] pix_col;

    pixel_exp_t  pixels_due [$];
    pixel_exp_t  want;

    int errors       = 0;
    int bytes_in     = 0;
    int pixels_out   = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_request = 0;

    function automatic logic [15:0] raw16_value(input logic [7:0] first,
                                                input logic [7:0] second);
        logic [15:0] v;
        int unsigned n;
        v = cfg.little_endian ? {second, first} : {first, second};
        n = cfg.valid_bits;
        if (n == 0) return 16'd0;
        if (n < 16) v = cfg.msb_aligned ? (v >> (16 - n)) : (v & ((16'd1 << n) - 16'd1));
        return v;
    endfunction

    // advance the unpacking state by one byte; queue the pixels when keep is set
    function automatic void unpack_byte(input logic [7:0] b, input logic rs, input bit keep);
        logic [15:0] px [4];
        pixel_exp_t  run [4];
        int unsigned glen, count, lim, n;
        n = 0;
        count = 0;
        if (rs) begin
            grp_phase = '0;
            pix_col = '0;
        end
        case (cfg.pixel_format)
            FMT_RAW10: glen = 5;
            FMT_RAW12: glen = 3;
            FMT_RAW16: glen = 2;
            default: begin
                grp_phase = '0;
                return;
            end
        endcase
        if (grp_phase + 1 < glen) begin
            grp_bytes[grp_phase[1:0]] = b;
            grp_phase = grp_phase + 3'd1;
            return;
        end
        grp_phase = '0;
        if (glen == 5) begin
            for (int i = 0; i < 4; i++) px[i] = {6'd0, grp_bytes[i], b[2*i +: 2]};
            count = 4;
        end else if (glen == 3) begin
            for (int i = 0; i < 2; i++) px[i] = {4'd0, grp_bytes[i], b[4*i +: 4]};
            count = 2;
        end else begin
            px[0] = raw16_value(grp_bytes[0], b);
            count = 1;
        end
        lim = (cfg.row_pixels < MAX_ROW_PIXELS) ? cfg.row_pixels : MAX_ROW_PIXELS;
        for (int i = 0; i < count; i++) begin
            // stride padding: column sticks at the limit
            if (pix_col >= lim) begin
                pix_col = lim[13:0];
                break;
            end
            run[n] = '{pixel: px[i], last: 1'b0, row_end: (pix_col + 1 == lim)};
            pix_col = pix_col + 14'd1;
            n++;
        end
        if (keep) begin
            for (int k = 0; k < n; k++) begin
                run[k].last = (k == n - 1);
                pixels_due.push_back(run[k]);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic rs, input bit keep);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_in++;
        unpack_byte(b, rs, keep);
    endtask

    // drain the output and give a byte that closes nothing time to pass through
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_PIXEL_FORMAT: begin
                cfg.pixel_format = value[1:0];
                held = {30'd0, value[1:0]};
            end
            REG_LITTLE_ENDIAN: begin
                cfg.little_endian = value[0];
                held = {31'd0, value[0]};
            end
            REG_MSB_ALIGNED: begin
                cfg.msb_aligned = value[0];
                held = {31'd0, value[0]};
            end
            REG_VALID_BITS: begin
                cfg.valid_bits = value[4:0];
                held = {27'd0, value[4:0]};
            end
            REG_ROW_PIXELS: begin
                cfg.row_pixels = value[13:0];
                held = {18'd0, value[13:0]};
            end
            default: held = '0;
        endcase
        // read the register straight back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== held) begin
            $error("register %0d: expected %h, actual %h", idx, held, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic step_row_t item(input logic [7:0] b, input logic rs);
        step_row_t r;
        r = '0;
        r.data_byte = b;
        r.row_start = rs;
        return r;
    endfunction

    // byte whose outcome is obvious: n pixels all of one value, none at row end
    function automatic step_row_t item_px(input logic [7:0] b, input logic rs,
                                          input logic [2:0] n, input logic [15:0] p);
        step_row_t r;
        r = item(b, rs);
        r.typed = 1'b1;
        r.n_px = n;
        r.pixel = p;
        return r;
    endfunction

    function automatic step_row_t cfg_row(input logic [2:0] idx, input logic [13:0] v);
        step_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = v;
        return r;
    endfunction

    function automatic rbu_cfg_t phase_setting(input int ph);
        case (ph)
            0: return {FMT_RAW10, 1'b1, 1'b0, 5'd16, 14'd6};
            1: return {FMT_RAW12, 1'b0, 1'b0, 5'd16, 14'd1};
            2: return {FMT_RAW16, 1'b1, 1'b1, 5'd12, 14'd5};
            3: return {FMT_RAW16, 1'b0, 1'b0, 5'd7, 14'd8192};
            4: return {FMT_RAW10, 1'b0, 1'b1, 5'd0, 14'd16383};
            5: return {FMT_RAW16, 1'b1, 1'b0, 5'd31, 14'd3};
            6: return {FMT_RAW16, 1'b0, 1'b1, 5'd1, 14'd9};
            7: return {FMT_RAW12, 1'b1, 1'b1, 5'd16, 14'd0};
            default: return {FMT_RAW10, 1'b0, 1'b0, 5'd16, 14'd2};
        endcase
    endfunction

    // output checker and watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pixels_out++;
            if (pixels_due.size() == 0) begin
                $error("pixel %h arrived with nothing expected", m_tdata);
                errors++;
            end else begin
                want = pixels_due.pop_front();
                if (m_tdata !== want.pixel) begin
                    $error("pixel_value: expected %h, actual %h", want.pixel, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %b, actual %b", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.row_end) begin
                    $error("row_end: expected %b, actual %b", want.row_end, m_tuser);
                    errors++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // receiver side: random back-pressure, or a long hold when asked
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        step_row_t   directed [$];
        step_row_t   r;
        rbu_cfg_t    s;
        int unsigned gl, ppg, groups, row_bytes, sent;

        cfg = {FMT_RAW10, 1'b1, 1'b0, 5'd16, 14'd1920};
        grp_phase = '0;
        pix_col = '0;
        for (int i = 0; i < 4; i++) grp_bytes[i] = '0;
        tx_idle_pct = 20;
        rx_idle_pct = 51;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: raw10, full-scale group
        directed.push_back(item_px(8'hFF, 1'b1, 3'd0, 16'h0));
        directed.push_back(item_px(8'hFF, 1'b0, 3'd0, 16'h0));
        directed.push_back(item_px(8'hFF, 1'b0, 3'd0, 16'h0));
        directed.push_back(item_px(8'hFF, 1'b0, 3'd0, 16'h0));
        directed.push_back(item_px(8'hFF, 1'b0, 3'd4, 16'h03FF));
        directed.push_back(cfg_row(REG_PIXEL_FORMAT, 14'(FMT_RAW12)));
        directed.push_back(item(8'hAB, 1'b1));
        directed.push_back(item(8'hCD, 1'b0));
        directed.push_back(item(8'h21, 1'b0));
        directed.push_back(cfg_row(REG_PIXEL_FORMAT, 14'(FMT_RAW16)));
        directed.push_back(item_px(8'h34, 1'b1, 3'd0, 16'h0));
        directed.push_back(item_px(8'h12, 1'b0, 3'd1, 16'h1234));
        directed.push_back(cfg_row(REG_LITTLE_ENDIAN, 14'd0));
        directed.push_back(item_px(8'hFF, 1'b1, 3'd0, 16'h0));
        directed.push_back(item_px(8'hFF, 1'b0, 3'd1, 16'hFFFF));
        directed.push_back(cfg_row(REG_MSB_ALIGNED, 14'd1));
        directed.push_back(cfg_row(REG_VALID_BITS, 14'd10));
        directed.push_back(item(8'hC3, 1'b1));
        directed.push_back(item(8'h5A, 1'b0));
        // no valid bits: sample reads as zero
        directed.push_back(cfg_row(REG_VALID_BITS, 14'd0));
        directed.push_back(item_px(8'hFF, 1'b1, 3'd0, 16'h0));
        directed.push_back(item_px(8'hFF, 1'b0, 3'd1, 16'h0));
        directed.push_back(cfg_row(REG_VALID_BITS, 14'd31));
        directed.push_back(item(8'hA5, 1'b1));
        directed.push_back(item(8'h5A, 1'b0));
        // unused format code swallows the byte
        directed.push_back(cfg_row(REG_PIXEL_FORMAT, 14'(FMT_UNUSED)));
        directed.push_back(item_px(8'h77, 1'b1, 3'd0, 16'h0));
        // short row: fourth pixel is padding
        directed.push_back(cfg_row(REG_PIXEL_FORMAT, 14'(FMT_RAW10)));
        directed.push_back(cfg_row(REG_ROW_PIXELS, 14'd3));
        directed.push_back(item(8'h11, 1'b1));
        directed.push_back(item(8'h22, 1'b0));
        directed.push_back(item(8'h33, 1'b0));
        directed.push_back(item(8'h44, 1'b0));
        directed.push_back(item(8'h1B, 1'b0));
        // format switch part way through a group closes it early
        directed.push_back(item(8'h55, 1'b1));
        directed.push_back(item(8'h66, 1'b0));
        directed.push_back(cfg_row(REG_PIXEL_FORMAT, 14'(FMT_RAW12)));
        directed.push_back(item(8'h9C, 1'b0));

        foreach (directed[i]) begin
            r = directed[i];
            if (r.is_cfg) begin
                wait_idle();
                write_reg(r.reg_idx, {18'd0, r.value});
            end else if (r.typed) begin
                for (int k = 0; k < r.n_px; k++)
                    pixels_due.push_back('{pixel: r.pixel, last: (k == r.n_px - 1),
                                           row_end: 1'b0});
                send_byte(r.data_byte, r.row_start, 1'b0);
            end else begin
                send_byte(r.data_byte, r.row_start, 1'b1);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 20;
                rx_idle_pct = 51;
            end else if (ph < 6) begin
                tx_idle_pct = 51;
                rx_idle_pct = 20;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            s = phase_setting(ph);
            wait_idle();
            write_reg(REG_PIXEL_FORMAT, {30'd0, s.pixel_format});
            write_reg(REG_LITTLE_ENDIAN, {31'd0, s.little_endian});
            write_reg(REG_MSB_ALIGNED, {31'd0, s.msb_aligned});
            write_reg(REG_VALID_BITS, {27'd0, s.valid_bits});
            write_reg(REG_ROW_PIXELS, {18'd0, s.row_pixels});
            // output held off while bytes keep coming, so the queue fills up
            if (ph == 6) hold_request = LONG_STALL;
            case (s.pixel_format)
                FMT_RAW10: begin gl = 5; ppg = 4; end
                FMT_RAW12: begin gl = 3; ppg = 2; end
                default:   begin gl = 2; ppg = 1; end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(9) == 0) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                    sent++;
                end else begin
                    groups = (s.row_pixels + ppg - 1) / ppg;
                    if (groups * gl <= 40) row_bytes = groups * gl + $urandom_range(3);
                    else row_bytes = gl * $urandom_range(2, 8);
                    if (row_bytes == 0) row_bytes = $urandom_range(1, 5);
                    for (int k = 0; k < row_bytes; k++) begin
                        send_byte(8'($urandom_range(255)), (k == 0), 1'b1);
                        sent++;
                    end
                end
            end
        end

        wait_idle();
        $display("covered %0d bytes over %0d register settings in raw10, raw12 and raw16",
                 bytes_in, N_PHASES + 1);
        $display("checked %0d pixels under three idle patterns and one long output hold",
                 pixels_out);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
